[hdl/brake_servo_and_blink_light_core_defines.svh]
// Assertion macros used by the checker of the brake servo and blink light core.
`ifndef BRAKE_SERVO_AND_BLINK_LIGHT_CORE_DEFINES_SVH
`define BRAKE_SERVO_AND_BLINK_LIGHT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSBL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BSBL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/bsbl_pkg.sv]
`default_nettype none

package bsbl_pkg;

	localparam int LEVEL_W    = 10;
	localparam int SERVO_W    = 9;
	localparam int MULT_W     = 4;
	localparam int TIME_W     = 32;
	localparam int INTERVAL_W = 14;
	localparam int SNUM_W     = 19;
	localparam int BNUM_W     = 14;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;
	localparam int REG_AW     = 3;

	typedef enum logic [REG_AW-1:0] {
		REG_ENABLE,
		REG_RELEASE_LEVEL,
		REG_FULL_BRAKE_LEVEL,
		REG_REST_LEVEL,
		REG_SERVO_REST,
		REG_SERVO_FULL,
		REG_BLINK_MAX_MULT,
		REG_BLINK_BASE_MS
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] lever;
		logic               braked;
		logic               stopped;
		logic [TIME_W-1:0]  now_ms;
	} bsbl_req_t;

	typedef struct packed {
		logic [SERVO_W-1:0] servo_one;
		logic [SERVO_W-1:0] servo_two;
		logic               servo_write;
		logic               valve_on;
		logic               light_on;
	} bsbl_res_t;

	typedef struct packed {
		logic               enable;
		logic [LEVEL_W-1:0] release_level;
		logic [LEVEL_W-1:0] full_brake_level;
		logic [LEVEL_W-1:0] rest_level;
		logic [SERVO_W-1:0] servo_rest;
		logic [SERVO_W-1:0] servo_full;
		logic [MULT_W-1:0]  blink_max_mult;
		logic [LEVEL_W-1:0] blink_base_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		enable:           1'b0,
		release_level:    10'd200,
		full_brake_level: 10'd100,
		rest_level:       10'd200,
		servo_rest:       9'd0,
		servo_full:       9'd270,
		blink_max_mult:   4'd10,
		blink_base_ms:    10'd50
	};

	// A classified request: flags for the special cases and the map operands as
	// sign and magnitude, ready for the dividers.
	typedef struct packed {
		logic               enable;
		logic               braked;
		logic               stopped;
		logic [TIME_W-1:0]  now_ms;
		logic               released;
		logic               servo_flat;
		logic               blink_flat;
		logic [MULT_W-1:0]  maxm;
		logic               sneg;
		logic [SNUM_W-1:0]  snum;
		logic [LEVEL_W-1:0] sden;
		logic               bneg;
		logic [BNUM_W-1:0]  bnum;
		logic [LEVEL_W-1:0] bden;
	} job_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_MUL,
		B_DONE
	} back_state_t;

endpackage

`default_nettype wire

[hdl/bsbl_if.sv]
`default_nettype none

interface bsbl_req_if import bsbl_pkg::*; ();
	logic      valid;
	logic      ready;
	bsbl_req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bsbl_res_if import bsbl_pkg::*; ();
	logic      valid;
	logic      ready;
	bsbl_res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/brake_servo_and_blink_light_core.sv]
// Brake servo and blink light controller. Each request is one control tick; it yields
// exactly one result with both servo positions, a servo write flag, the valve level and
// the brake light level. Requests are taken into a small queue and worked one at a time.
// In the back end a request is taken from the queue and starts the dividers; the servo map
// divider retires two quotient bits per cycle over a 19-bit numerator; then the maps and
// clamps are applied, the blink interval is multiplied and last the state is updated and
// the result register loaded. A result waiting at the output holds the back end, while new
// requests still enter the queue until it is full.
// Registers are written over the APB port at byte address 4*i and should be changed only
// while no request is in flight.
`default_nettype none

module brake_servo_and_blink_light_core import bsbl_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	bsbl_req_if.sink           req,
	bsbl_res_if.source         res,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     cfg_wr;
	logic     q_full;
	logic     q_empty;
	logic     push;
	logic     pop;
	job_t     job_in;
	job_t     job_out;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ENABLE:           cfg_q.enable           <= pwdata[0];
				REG_RELEASE_LEVEL:    cfg_q.release_level    <= pwdata[LEVEL_W-1:0];
				REG_FULL_BRAKE_LEVEL: cfg_q.full_brake_level <= pwdata[LEVEL_W-1:0];
				REG_REST_LEVEL:       cfg_q.rest_level       <= pwdata[LEVEL_W-1:0];
				REG_SERVO_REST:       cfg_q.servo_rest       <= pwdata[SERVO_W-1:0];
				REG_SERVO_FULL:       cfg_q.servo_full       <= pwdata[SERVO_W-1:0];
				REG_BLINK_MAX_MULT:   cfg_q.blink_max_mult   <= pwdata[MULT_W-1:0];
				REG_BLINK_BASE_MS:    cfg_q.blink_base_ms    <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_ENABLE:           prdata[0]           = cfg_q.enable;
			REG_RELEASE_LEVEL:    prdata[LEVEL_W-1:0] = cfg_q.release_level;
			REG_FULL_BRAKE_LEVEL: prdata[LEVEL_W-1:0] = cfg_q.full_brake_level;
			REG_REST_LEVEL:       prdata[LEVEL_W-1:0] = cfg_q.rest_level;
			REG_SERVO_REST:       prdata[SERVO_W-1:0] = cfg_q.servo_rest;
			REG_SERVO_FULL:       prdata[SERVO_W-1:0] = cfg_q.servo_full;
			REG_BLINK_MAX_MULT:   prdata[MULT_W-1:0]  = cfg_q.blink_max_mult;
			REG_BLINK_BASE_MS:    prdata[LEVEL_W-1:0] = cfg_q.blink_base_ms;
			default: ;
		endcase
	end

	bsbl_front u_front (
		.cfg    (cfg_q),
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.job    (job_in)
	);

	bsbl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job_in),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rdata  (job_out)
	);

	bsbl_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.job     (job_out),
		.pop     (pop),
		.res     (res)
	);

endmodule

`default_nettype wire

[hdl/bsbl_front.sv]
`default_nettype none

module bsbl_front import bsbl_pkg::*; (
	input  cfg_t          cfg,
	bsbl_req_if.sink      req,
	input  logic          q_full,
	output logic          push,
	output job_t          job
);

	logic signed [LEVEL_W:0] dn;
	logic signed [LEVEL_W:0] dd;
	logic signed [LEVEL_W:0] bx;
	logic signed [LEVEL_W:0] br;
	logic signed [SERVO_W:0] span;
	logic [LEVEL_W-1:0]      dn_mag;
	logic [LEVEL_W-1:0]      dd_mag;
	logic [LEVEL_W-1:0]      bx_mag;
	logic [LEVEL_W-1:0]      br_mag;
	logic [SERVO_W-1:0]      span_mag;
	logic [MULT_W-1:0]       maxm;
	logic [MULT_W-1:0]       mstep;

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	assign dn   = $signed({1'b0, req.data.lever}) - $signed({1'b0, cfg.full_brake_level});
	assign dd   = $signed({1'b0, cfg.release_level}) - $signed({1'b0, cfg.full_brake_level});
	assign bx   = $signed({1'b0, req.data.lever}) - $signed({1'b0, cfg.rest_level});
	assign br   = $signed({1'b0, cfg.full_brake_level}) - $signed({1'b0, cfg.rest_level});
	assign span = $signed({1'b0, cfg.servo_full}) - $signed({1'b0, cfg.servo_rest});

	assign dn_mag   = dn[LEVEL_W] ? LEVEL_W'(-dn) : LEVEL_W'(dn);
	assign dd_mag   = dd[LEVEL_W] ? LEVEL_W'(-dd) : LEVEL_W'(dd);
	assign bx_mag   = bx[LEVEL_W] ? LEVEL_W'(-bx) : LEVEL_W'(bx);
	assign br_mag   = br[LEVEL_W] ? LEVEL_W'(-br) : LEVEL_W'(br);
	assign span_mag = span[SERVO_W] ? SERVO_W'(-span) : SERVO_W'(span);

	assign maxm  = (cfg.blink_max_mult == '0) ? MULT_W'(1) : cfg.blink_max_mult;
	assign mstep = maxm - MULT_W'(1);

	always_comb begin
		job.enable     = cfg.enable;
		job.braked     = req.data.braked;
		job.stopped    = req.data.stopped;
		job.now_ms     = req.data.now_ms;
		job.released   = req.data.lever > cfg.release_level;
		job.servo_flat = cfg.release_level == cfg.full_brake_level;
		job.blink_flat = br == '0;
		job.maxm       = maxm;
		job.sneg       = dn[LEVEL_W] ^ span[SERVO_W] ^ dd[LEVEL_W];
		job.snum       = SNUM_W'(dn_mag) * SNUM_W'(span_mag);
		job.sden       = dd_mag;
		// The blink map numerator is the negated lever offset times the step.
		job.bneg       = !bx[LEVEL_W] ^ br[LEVEL_W];
		job.bnum       = BNUM_W'(bx_mag) * BNUM_W'(mstep);
		job.bden       = br_mag;
	end

endmodule

`default_nettype wire

[hdl/bsbl_queue.sv]
`default_nettype none

module bsbl_queue import bsbl_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

[hdl/bsbl_div.sv]
`default_nettype none

module bsbl_div #(
	parameter int NUM_W = 8,
	parameter int DEN_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	localparam int STEPS = (NUM_W + 1) / 2;
	localparam int PAD_W = 2 * STEPS;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PAD_W-1:0] acc_q;
	logic [PAD_W-1:0] acc_d;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] rem_d;
	logic [DEN_W-1:0] den_q;

	// Two restoring steps per cycle; quotient bits shift in from the bottom.
	always_comb begin
		logic [DEN_W:0]   trial;
		logic [PAD_W-1:0] a;
		logic [DEN_W-1:0] r;
		a = acc_q;
		r = rem_q;
		for (int i = 0; i < 2; i++) begin
			trial = {r, a[PAD_W-1]};
			a = {a[PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial = trial - {1'b0, den_q};
				a[0] = 1'b1;
			end
			r = trial[DEN_W-1:0];
		end
		acc_d = a;
		rem_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= PAD_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
		end
	end

	assign busy = busy_q;
	assign quo  = acc_q[NUM_W-1:0];

endmodule

`default_nettype wire

[hdl/bsbl_back.sv]
`default_nettype none

module bsbl_back import bsbl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_empty,
	input  job_t       job,
	output logic       pop,
	bsbl_res_if.source res
);

	localparam int SQ_W = SNUM_W + 2;
	localparam int BQ_W = BNUM_W + 2;
	localparam logic signed [BQ_W-1:0] BQ_ONE = BQ_W'(1);

	back_state_t state_q;
	back_state_t state_d;
	job_t        job_q;

	logic div_start;
	logic calc_load;
	logic ivl_load;
	logic out_load;
	logic sdiv_busy;
	logic bdiv_busy;
	logic [SNUM_W-1:0] squo;
	logic [BNUM_W-1:0] bquo;

	logic signed [SQ_W-1:0] sq_mag;
	logic signed [SQ_W-1:0] sq;
	logic signed [SQ_W-1:0] sa;
	logic signed [SQ_W-1:0] sb;
	logic signed [SQ_W-1:0] s_lo_x;
	logic signed [SQ_W-1:0] s_hi_x;
	logic [SERVO_W-1:0]     s_lo;
	logic [SERVO_W-1:0]     s_hi;
	logic [SERVO_W-1:0]     sa_c;
	logic [SERVO_W-1:0]     sb_c;
	logic [SERVO_W-1:0]     s1_d;
	logic [SERVO_W-1:0]     s2_d;

	logic signed [BQ_W-1:0] bq_mag;
	logic signed [BQ_W-1:0] bq;
	logic signed [BQ_W-1:0] bm;
	logic signed [BQ_W-1:0] maxm_x;
	logic [MULT_W-1:0]      mult_d;

	logic [SERVO_W-1:0]    s1_q;
	logic [SERVO_W-1:0]    s2_q;
	logic [MULT_W-1:0]     mult_q;
	logic [INTERVAL_W-1:0] interval_q;

	logic [SERVO_W-1:0] last_servo_q;
	logic [SERVO_W-1:0] last_servo_d;
	logic               valve_q;
	logic               valve_d;
	logic               light_q;
	logic               light_d;
	logic [TIME_W-1:0]  last_toggle_q;
	logic [TIME_W-1:0]  last_toggle_d;
	logic [TIME_W-1:0]  elapsed;
	logic               wr;

	logic      out_valid_q;
	bsbl_res_t out_data_q;
	bsbl_res_t out_data_d;

	bsbl_div #(.NUM_W(SNUM_W), .DEN_W(LEVEL_W)) u_sdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (job.snum),
		.den    (job.sden),
		.busy   (sdiv_busy),
		.quo    (squo)
	);

	bsbl_div #(.NUM_W(BNUM_W), .DEN_W(LEVEL_W)) u_bdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (job.bnum),
		.den    (job.bden),
		.busy   (bdiv_busy),
		.quo    (bquo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) state_d = B_DIV;
			end
			B_DIV: begin
				if (!sdiv_busy && !bdiv_busy) state_d = B_MUL;
			end
			B_MUL: begin
				state_d = B_DONE;
			end
			B_DONE: begin
				if (!out_valid_q || res.ready) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		calc_load = 1'b0;
		ivl_load  = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			B_IDLE: div_start = !q_empty;
			B_DIV:  calc_load = !sdiv_busy && !bdiv_busy;
			B_MUL:  ivl_load  = 1'b1;
			B_DONE: out_load  = !out_valid_q || res.ready;
			default: ;
		endcase
	end

	assign pop = div_start;

	// Servo map: one quotient serves both servos, with opposite signs.
	always_comb begin
		sq_mag = $signed({2'b00, squo});
		sq     = job_q.sneg ? -sq_mag : sq_mag;
		s_lo   = (cfg.servo_rest < cfg.servo_full) ? cfg.servo_rest : cfg.servo_full;
		s_hi   = (cfg.servo_rest < cfg.servo_full) ? cfg.servo_full : cfg.servo_rest;
		s_lo_x = $signed({{(SQ_W - SERVO_W){1'b0}}, s_lo});
		s_hi_x = $signed({{(SQ_W - SERVO_W){1'b0}}, s_hi});
		sa     = $signed({{(SQ_W - SERVO_W){1'b0}}, cfg.servo_full}) - sq;
		sb     = $signed({{(SQ_W - SERVO_W){1'b0}}, cfg.servo_rest}) + sq;
		sa_c   = (sa < s_lo_x) ? s_lo : ((sa > s_hi_x) ? s_hi : sa[SERVO_W-1:0]);
		sb_c   = (sb < s_lo_x) ? s_lo : ((sb > s_hi_x) ? s_hi : sb[SERVO_W-1:0]);
		if (job_q.released) begin
			s1_d = cfg.servo_rest;
			s2_d = cfg.servo_full;
		end else if (job_q.servo_flat) begin
			s1_d = cfg.servo_full;
			s2_d = cfg.servo_rest;
		end else begin
			s1_d = sa_c;
			s2_d = sb_c;
		end
	end

	always_comb begin
		bq_mag = $signed({2'b00, bquo});
		bq     = job_q.bneg ? -bq_mag : bq_mag;
		maxm_x = $signed({{(BQ_W - MULT_W){1'b0}}, job_q.maxm});
		bm     = bq + maxm_x;
		if (job_q.blink_flat || bm < BQ_ONE) begin
			mult_d = MULT_W'(1);
		end else if (bm > maxm_x) begin
			mult_d = job_q.maxm;
		end else begin
			mult_d = bm[MULT_W-1:0];
		end
	end

	assign elapsed = job_q.now_ms - last_toggle_q;

	always_comb begin
		light_d       = light_q;
		valve_d       = valve_q;
		last_toggle_d = last_toggle_q;
		last_servo_d  = last_servo_q;
		wr            = 1'b0;
		if (job_q.enable) begin
			valve_d = job_q.braked;
			if (!job_q.braked) begin
				light_d = 1'b0;
			end else if (job_q.stopped) begin
				light_d = 1'b1;
			end else if (elapsed >= TIME_W'(interval_q)) begin
				light_d       = !light_q;
				last_toggle_d = job_q.now_ms;
			end
			if (!(s1_q == cfg.servo_rest && last_servo_q == s1_q)) begin
				wr           = 1'b1;
				last_servo_d = s1_q;
			end
		end
		out_data_d.servo_one   = job_q.enable ? s1_q : '0;
		out_data_d.servo_two   = job_q.enable ? s2_q : '0;
		out_data_d.servo_write = wr;
		out_data_d.valve_on    = valve_d;
		out_data_d.light_on    = light_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			out_valid_q   <= 1'b0;
			last_servo_q  <= '0;
			valve_q       <= 1'b0;
			light_q       <= 1'b0;
			last_toggle_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q   <= 1'b1;
				last_servo_q  <= last_servo_d;
				valve_q       <= valve_d;
				light_q       <= light_d;
				last_toggle_q <= last_toggle_d;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) job_q <= job;
		if (calc_load) begin
			s1_q   <= s1_d;
			s2_q   <= s2_d;
			mult_q <= mult_d;
		end
		if (ivl_load) interval_q <= INTERVAL_W'(mult_q) * INTERVAL_W'(cfg.blink_base_ms);
		if (out_load) out_data_q <= out_data_d;
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_data_q;

endmodule

`default_nettype wire

[hdl/bsbl_checker.sv]
`default_nettype none

`include "brake_servo_and_blink_light_core_defines.svh"

module bsbl_checker import bsbl_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               res_valid,
	input logic               res_ready,
	input bsbl_res_t          res_data,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic               pready,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	input logic [PDATA_W-1:0] prdata
);

	`BSBL_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data), "Stalled result changed or dropped.")

	`BSBL_ASSERT_IMP(a_light_needs_valve, clk, arst_n, res_valid && !res_data.valve_on, !res_data.light_on, "Brake light on while the valve is off.")

	`BSBL_ASSERT_IMP(a_ready_falls_on_accept, clk, arst_n, $fell(req_ready), $past(req_valid && req_ready), "Request ready fell without an accepted request.")

	`BSBL_ASSERT_IMP(a_enable_readback, clk, arst_n, (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_ENABLE) ##1 (paddr[PADDR_W-1:2] == REG_ENABLE), prdata[0] == $past(pwdata[0]), "Enable register does not read back the written value.")

endmodule

bind brake_servo_and_blink_light_core bsbl_checker u_bsbl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.pready    (pready),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

`default_nettype wire
